FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/dnnm_pkg.sv
`timescale 1ns / 1ps

package dnnm_pkg;

    localparam int OP_W    = 2;
    localparam int ELEM_W  = 16;
    localparam int IN_W    = 24;
    localparam int INDEX_W = 11;
    localparam int DIST_W  = 19;
    localparam int OUT_W   = 32;
    localparam int LIMIT_W = 37;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 37'd137434759201;
    localparam logic [DIST_W-1:0]  DIST_ONES   = '1;
    localparam logic [INDEX_W-1:0] INDEX_NONE  = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

FILE: design/descriptor_nearest_neighbor_match.sv
`timescale 1ns / 1ps

// Brute-force nearest-neighbor matcher over squared L2 distance. The transaction that
// completes a query starts a search over every complete reference descriptor: the
// reference memory has one read port, so the search reads one element per cycle
// through a four-stage read, subtract, square and accumulate pipeline, and the floor
// square root then resolves one result bit per cycle. The result waits in an output
// register while new transactions are taken.
module descriptor_nearest_neighbor_match #(
    parameter int DESC_LEN  = 32,
    parameter int MAX_REFS  = 1024,
    parameter int ELEM_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op [1:0], elem [17:2], zero padding above.
    input  logic [dnnm_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // match_index [10:0], distance [29:11], overflow [30], zero padding above.
    output logic [dnnm_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [dnnm_pkg::LIMIT_W-1:0] cfg_wr_data
);
    import dnnm_pkg::*;

    `include "assert_macros.svh"

    localparam int EW     = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;
    localparam int DEPTH  = MAX_REFS * DESC_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QA_W   = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_REFS + 1);
    localparam int IDX_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int ACC_W  = 2 * EW + $clog2(DESC_LEN);
    localparam int CMP_W  = (ACC_W > LIMIT_W) ? ACC_W : LIMIT_W;
    localparam int RES_W  = (ACC_W + 1) / 2;
    localparam int RAD_W  = 2 * RES_W;
    localparam int SQ_CW  = $clog2(RES_W);
    localparam int MW     = (RES_W > DIST_W) ? RES_W : DIST_W;

    localparam logic [QA_W-1:0]  LAST_ELEM = QA_W'(DESC_LEN - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_REFS);

    logic signed [EW-1:0] ref_mem [DEPTH];
    logic signed [EW-1:0] qry_mem [DESC_LEN];

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   ref_count_reg;
    logic [QA_W-1:0]    load_pos_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [QA_W-1:0]    qry_pos_reg;
    logic               ovf_reg;

    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [QA_W-1:0]    elem_cnt_reg;
    logic [CNT_W-1:0]   ref_idx_reg;

    logic signed [EW-1:0] ref_rd_reg, qry_rd_reg;
    logic                 p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic                 p1_last_reg, p2_last_reg, p3_last_reg;
    logic [IDX_W-1:0]     p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [EW-1:0]        absd_reg;
    logic [2*EW-1:0]      sq_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [CMP_W-1:0]     best_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 found_reg;

    logic [RAD_W-1:0]   rad_reg;
    logic [RES_W:0]     rem_reg;
    logic [RES_W-1:0]   root_reg;
    logic [SQ_CW-1:0]   sq_cnt_reg;

    logic               m_tvalid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_ovf_reg;

    logic [OP_W-1:0]    in_op;
    logic [EW-1:0]      in_elem;
    logic               in_fire;
    logic               store_full;
    logic               ref_we;
    logic               query_done;
    logic               issue_en;
    logic               pipe_busy;
    logic               out_load;

    logic signed [EW:0] diff;
    logic [ACC_W-1:0]   acc_sum;
    logic [RES_W+2:0]   rem_shift;
    logic [RES_W+2:0]   trial;
    logic [RES_W+2:0]   rem_diff;
    logic               rem_ge;
    logic [MW-1:0]      root_ext;
    logic [DIST_W-1:0]  dist_sat;

    assign in_op      = s_tdata[OP_W-1:0];
    assign in_elem    = s_tdata[OP_W +: EW];
    assign in_fire    = s_tvalid && s_tready;
    assign store_full = (ref_count_reg == FULL_CNT);
    assign ref_we     = in_fire && (in_op == OP_APPEND) && !store_full;
    assign query_done = in_fire && (in_op == OP_QUERY) && (qry_pos_reg == LAST_ELEM);
    assign issue_en   = (state_reg == ST_SCAN) && (ref_idx_reg != ref_count_reg);
    assign pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg;

    assign diff     = $signed({ref_rd_reg[EW-1], ref_rd_reg})
                      - $signed({qry_rd_reg[EW-1], qry_rd_reg});
    assign acc_sum  = acc_reg + ACC_W'(sq_reg);

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign rem_ge    = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    assign root_ext = MW'(root_reg);
    assign dist_sat = (root_ext > MW'(DIST_ONES)) ? DIST_ONES : DIST_W'(root_reg);

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (query_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue_en && !pipe_busy)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[wr_addr_reg] <= in_elem;
        end
        ref_rd_reg <= ref_mem[scan_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_op == OP_QUERY))
        begin
            qry_mem[qry_pos_reg] <= in_elem;
        end
        qry_rd_reg <= qry_mem[elem_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            ref_count_reg <= '0;
            load_pos_reg  <= '0;
            wr_addr_reg   <= '0;
            qry_pos_reg   <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                case (in_op)
                    OP_CLEAR:
                    begin
                        ref_count_reg <= '0;
                        load_pos_reg  <= '0;
                        wr_addr_reg   <= '0;
                        ovf_reg       <= 1'b0;
                    end
                    OP_APPEND:
                    begin
                        if (store_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            wr_addr_reg <= wr_addr_reg + ADDR_W'(1);
                            if (load_pos_reg == LAST_ELEM)
                            begin
                                load_pos_reg  <= '0;
                                ref_count_reg <= ref_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                load_pos_reg <= load_pos_reg + QA_W'(1);
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (qry_pos_reg == LAST_ELEM)
                        begin
                            qry_pos_reg <= '0;
                        end
                        else
                        begin
                            qry_pos_reg <= qry_pos_reg + QA_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Address generation for the search, the valid tags of the datapath, and the accumulator and found flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            elem_cnt_reg  <= '0;
            ref_idx_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (query_done)
            begin
                scan_addr_reg <= '0;
                elem_cnt_reg  <= '0;
                ref_idx_reg   <= '0;
                acc_reg       <= '0;
                found_reg     <= 1'b0;
            end
            else if (issue_en)
            begin
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                if (elem_cnt_reg == LAST_ELEM)
                begin
                    elem_cnt_reg <= '0;
                    ref_idx_reg  <= ref_idx_reg + CNT_W'(1);
                end
                else
                begin
                    elem_cnt_reg <= elem_cnt_reg + QA_W'(1);
                end
            end
            p1_valid_reg <= issue_en;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (p3_valid_reg)
            begin
                if (p3_last_reg)
                begin
                    acc_reg <= '0;
                    if (CMP_W'(acc_sum) < best_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_last_reg <= (elem_cnt_reg == LAST_ELEM);
        p1_idx_reg  <= ref_idx_reg[IDX_W-1:0];
        p2_last_reg <= p1_last_reg;
        p2_idx_reg  <= p1_idx_reg;
        p3_last_reg <= p2_last_reg;
        p3_idx_reg  <= p2_idx_reg;
        absd_reg    <= diff[EW] ? EW'(-diff) : EW'(diff);
        sq_reg      <= absd_reg * absd_reg;
        if (query_done)
        begin
            best_reg <= CMP_W'(limit_reg);
        end
        else if (p3_valid_reg && p3_last_reg && (CMP_W'(acc_sum) < best_reg))
        begin
            best_reg     <= CMP_W'(acc_sum);
            best_idx_reg <= p3_idx_reg;
        end
    end

    // Floor square root, one result bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= '0;
        end
        else if ((state_reg == ST_SCAN) && (state_next == ST_SQRT))
        begin
            sq_cnt_reg <= SQ_CW'(RES_W - 1);
        end
        else if (state_reg == ST_SQRT)
        begin
            sq_cnt_reg <= sq_cnt_reg - SQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && (state_next == ST_SQRT))
        begin
            rad_reg  <= RAD_W'(best_reg[ACC_W-1:0]);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_ge)
            begin
                rem_reg  <= rem_diff[RES_W:0];
                root_reg <= {root_reg[RES_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[RES_W:0];
                root_reg <= {root_reg[RES_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= found_reg ? INDEX_W'(best_idx_reg) : INDEX_NONE;
            out_dist_reg  <= found_reg ? dist_sat : DIST_ONES;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_ovf_reg, out_dist_reg, out_index_reg};

    `ASSERT_ALWAYS(a_count_in_range, ref_count_reg <= FULL_CNT)
    `ASSERT_IMPLY(a_partial_has_room, load_pos_reg != '0, !store_full)
    `ASSERT_IMPLY(a_sqrt_after_drain, state_reg == ST_SQRT, !pipe_busy && !issue_en)
    `ASSERT_IMPLY(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg == ST_DONE))

endmodule
